// ----- sv/rtpd_pkg.sv -----
// Shared types, constants and the arctangent table for the rect-to-polar block.
// No dependencies.
`default_nettype none
package rtpd_pkg;

  localparam int unsigned AtanEntries = 24;
  localparam int unsigned SqrtSteps   = 16;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned XyWidth     = 36;
  localparam int unsigned ZWidth      = 25;

  localparam logic signed [ZWidth-1:0] Deg90Q16 = 25'sd5898240;
  localparam logic signed [15:0]       Deg90Q7  = 16'sd11520;
  localparam logic signed [15:0]       Deg180Q7 = 16'sd23040;

  localparam logic [22:0] AtanDegQ16 [AtanEntries] = '{
    23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
    23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833,
    23'd917, 23'd458, 23'd229, 23'd115, 23'd57, 23'd29,
    23'd14, 23'd7, 23'd4, 23'd2, 23'd1, 23'd0
  };

  typedef enum logic [3:0] {
    CLS_ORIGIN,
    CLS_POS_IM,
    CLS_NEG_IM,
    CLS_POS_RE,
    CLS_NEG_RE,
    CLS_Q1,
    CLS_Q2,
    CLS_Q3,
    CLS_Q4
  } rtpd_cls_e;

  typedef struct packed {
    logic signed [15:0] real_part;
    logic signed [15:0] imag_part;
  } rtpd_in_t;

  typedef struct packed {
    logic [15:0]        magnitude;
    logic signed [15:0] angle_deg;
    logic               invalid;
  } rtpd_out_t;

  typedef struct packed {
    rtpd_cls_e   cls;
    logic [15:0] abs_re;
    logic [15:0] abs_im;
    logic [30:0] sq_re;
    logic [30:0] sq_im;
  } rtpd_job_t;

  typedef struct packed {
    rtpd_cls_e                 cls;
    logic signed [XyWidth-1:0] x;
    logic signed [XyWidth-1:0] y;
    logic signed [ZWidth-1:0]  z;
    logic [31:0]               rad;
    logic [19:0]               rem;
    logic [15:0]               root;
  } rtpd_stage_t;

endpackage
`default_nettype wire

// ----- sv/rect_to_polar_degrees_top.sv -----
// Rect-to-polar top level: front end, word queue, CORDIC/sqrt back end.
// Depends on rtpd_pkg, rtpd_front, rtpd_queue, rtpd_back.
//
//   channel  signals                             word type
//   in       in_valid_i / in_ready_o / in_word_i     rtpd_in_t
//   out      out_valid_o / out_ready_i / out_word_o  rtpd_out_t
//
// One word accepted per cycle when the output is drained.
// A word passes the front register, the queue, the back stage registers and the output
// register; the back pipeline depth is set by the CORDIC and square-root stages.
// Output backpressure stalls the whole back pipeline; the queue absorbs the front.
// Reset clears only valid bits and the queue pointers and count.
`default_nettype none
module rect_to_polar_degrees_top #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire rtpd_pkg::rtpd_in_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output rtpd_pkg::rtpd_out_t     out_word_o
);
  import rtpd_pkg::*;

  logic      fr_valid, fr_ready, q_valid, q_pop;
  rtpd_job_t fr_job, q_job;

  rtpd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .job_valid_o (fr_valid),
    .job_ready_i (fr_ready),
    .job_o       (fr_job)
  );

  rtpd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (fr_valid),
    .push_ready_o (fr_ready),
    .push_word_i  (fr_job),
    .pop_i        (q_pop),
    .pop_valid_o  (q_valid),
    .pop_word_o   (q_job)
  );

  rtpd_back #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_pop_o   (q_pop),
    .job_i       (q_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule
`default_nettype wire

// ----- sv/rtpd_front.sv -----
// Front end: classification, absolute values and squares into the job register.
// Depends on rtpd_pkg.
`default_nettype none
module rtpd_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire rtpd_pkg::rtpd_in_t in_word_i,
  output logic                   job_valid_o,
  input  wire logic              job_ready_i,
  output rtpd_pkg::rtpd_job_t    job_o
);
  import rtpd_pkg::*;

  logic      valid_q, valid_d;
  rtpd_job_t job_q, job_d;
  logic signed [16:0] re_s, im_s;
  logic [15:0] abs_re, abs_im;
  logic [31:0] sq_re, sq_im;

  assign in_ready_o  = !valid_q || job_ready_i;
  assign job_valid_o = valid_q;
  assign job_o       = job_q;

  always_comb begin
    re_s   = {in_word_i.real_part[15], in_word_i.real_part};
    im_s   = {in_word_i.imag_part[15], in_word_i.imag_part};
    abs_re = re_s[16] ? 16'(-re_s) : 16'(re_s);
    abs_im = im_s[16] ? 16'(-im_s) : 16'(im_s);
    sq_re  = abs_re * abs_re;
    sq_im  = abs_im * abs_im;
    job_d.abs_re = abs_re;
    job_d.abs_im = abs_im;
    job_d.sq_re  = sq_re[30:0];
    job_d.sq_im  = sq_im[30:0];
    priority if (re_s == '0 && im_s == '0) begin
      job_d.cls = CLS_ORIGIN;
    end else if (re_s == '0) begin
      job_d.cls = im_s[16] ? CLS_NEG_IM : CLS_POS_IM;
    end else if (im_s == '0) begin
      job_d.cls = re_s[16] ? CLS_NEG_RE : CLS_POS_RE;
    end else if (!re_s[16] && !im_s[16]) begin
      job_d.cls = CLS_Q1;
    end else if (re_s[16] && !im_s[16]) begin
      job_d.cls = CLS_Q2;
    end else if (re_s[16]) begin
      job_d.cls = CLS_Q3;
    end else begin
      job_d.cls = CLS_Q4;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      job_q <= job_d;
    end
  end

endmodule
`default_nettype wire

// ----- sv/rtpd_queue.sv -----
// Short word queue between front end and back end.
// Depends on rtpd_pkg.
`default_nettype none
module rtpd_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  output logic                    push_ready_o,
  input  wire rtpd_pkg::rtpd_job_t push_word_i,
  input  wire logic               pop_i,
  output logic                    pop_valid_o,
  output rtpd_pkg::rtpd_job_t     pop_word_o
);
  import rtpd_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  rtpd_job_t          mem_q [QueueDepth];
  logic [PtrW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]      cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign push_ready_o = cnt_q != (PtrW+1)'(QueueDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_word_o   = mem_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_word_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(QueueDepth)) else $error("queue count overflow");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == (PtrW+1)'(QueueDepth)) |-> (wr_q == rd_q))
    else $error("queue pointers disagree with count");
`endif

endmodule
`default_nettype wire

// ----- sv/rtpd_back.sv -----
// Back end: pipelined CORDIC vectoring and bit-per-stage square root, then
// quadrant restore and rounding into the output register. Depends on rtpd_pkg.
`default_nettype none
module rtpd_back #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               job_valid_i,
  output logic                    job_pop_o,
  input  wire rtpd_pkg::rtpd_job_t job_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output rtpd_pkg::rtpd_out_t     out_word_o
);
  import rtpd_pkg::*;

  localparam int unsigned NumCordic = (CORDIC_STAGES > AtanEntries) ? AtanEntries
                                                                      : CORDIC_STAGES;
  localparam int unsigned NumStages = (NumCordic > SqrtSteps) ? NumCordic : SqrtSteps;

  rtpd_stage_t stg_q [NumStages+1];
  rtpd_stage_t stg_d [NumStages+1];
  logic [NumStages:0] vld_q;
  logic        en;
  logic        out_valid_q;
  rtpd_out_t   out_q, out_d;

  assign en          = !out_valid_q || out_ready_i;
  assign job_pop_o   = job_valid_i && en;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    stg_d[0].cls  = job_i.cls;
    stg_d[0].x    = XyWidth'({job_i.abs_re, 16'h0000});
    stg_d[0].y    = XyWidth'({job_i.abs_im, 16'h0000});
    stg_d[0].z    = '0;
    stg_d[0].rad  = {1'b0, job_i.sq_re} + {1'b0, job_i.sq_im};
    stg_d[0].rem  = '0;
    stg_d[0].root = '0;
  end

  for (genvar k = 0; k < NumStages; k++) begin : g_stage
    always_comb begin
      logic signed [XyWidth-1:0] dx, dy;
      logic signed [ZWidth-1:0]  da;
      logic [19:0]               r2, t;
      stg_d[k+1] = stg_q[k];
      if (k < NumCordic) begin
        dx = stg_q[k].y >>> k;
        dy = stg_q[k].x >>> k;
        da = ZWidth'(AtanDegQ16[k]);
        if (stg_q[k].y > 0) begin
          stg_d[k+1].x = stg_q[k].x + dx;
          stg_d[k+1].y = stg_q[k].y - dy;
          stg_d[k+1].z = stg_q[k].z + da;
        end else begin
          stg_d[k+1].x = stg_q[k].x - dx;
          stg_d[k+1].y = stg_q[k].y + dy;
          stg_d[k+1].z = stg_q[k].z - da;
        end
      end
      if (k < SqrtSteps) begin
        r2 = {stg_q[k].rem[17:0], stg_q[k].rad[31:30]};
        t  = {2'b00, stg_q[k].root, 2'b01};
        stg_d[k+1].rad = {stg_q[k].rad[29:0], 2'b00};
        if (r2 >= t) begin
          stg_d[k+1].rem  = r2 - t;
          stg_d[k+1].root = {stg_q[k].root[14:0], 1'b1};
        end else begin
          stg_d[k+1].rem  = r2;
          stg_d[k+1].root = {stg_q[k].root[14:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    logic signed [ZWidth-1:0] zc, zr;
    logic signed [15:0]       t;
    rtpd_stage_t              s;
    s = stg_q[NumStages];
    if (s.z < 0) begin
      zc = '0;
    end else if (s.z > Deg90Q16) begin
      zc = Deg90Q16;
    end else begin
      zc = s.z;
    end
    zr = zc + ZWidth'(256);
    t  = 16'({2'b00, zr[22:9]});
    out_d.magnitude = s.root + 16'(s.rem > {4'b0000, s.root});
    out_d.invalid   = 1'b0;
    unique case (s.cls)
      CLS_ORIGIN: begin
        out_d.magnitude = '0;
        out_d.angle_deg = '0;
        out_d.invalid   = 1'b1;
      end
      CLS_POS_IM: out_d.angle_deg = Deg90Q7;
      CLS_NEG_IM: out_d.angle_deg = -Deg90Q7;
      CLS_POS_RE: out_d.angle_deg = '0;
      CLS_NEG_RE: out_d.angle_deg = Deg180Q7;
      CLS_Q1:     out_d.angle_deg = t;
      CLS_Q2:     out_d.angle_deg = Deg180Q7 - t;
      CLS_Q4:     out_d.angle_deg = -t;
      default:    out_d.angle_deg = t - Deg180Q7;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[NumStages-1:0], job_valid_i};
      out_valid_q <= vld_q[NumStages];
    end
  end

  for (genvar k = 0; k <= NumStages; k++) begin : g_reg
    always_ff @(posedge clk_i) begin
      if (en) begin
        stg_q[k] <= (k == 0) ? stg_d[0] : stg_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.invalid) |-> (out_q.magnitude == '0 && out_q.angle_deg == '0))
    else $error("origin word carries nonzero result");
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.angle_deg >= -Deg180Q7 && out_q.angle_deg <= Deg180Q7))
    else $error("angle out of range");
`endif

endmodule
`default_nettype wire
